### hw/rtl/hpt_pkg.sv
`default_nettype none
package hpt_pkg;

  localparam int unsigned WORD_W = 64;
  localparam int unsigned CNT_W  = 7;

  // measurement kinds
  localparam logic [1:0] FUNC_TEMP  = 2'd0;
  localparam logic [1:0] FUNC_PRESS = 2'd1;
  localparam logic [1:0] FUNC_HUM   = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_TEMP       = 3'd0;
  localparam logic [2:0] REG_PRESS_LOW  = 3'd1;
  localparam logic [2:0] REG_PRESS_HIGH = 3'd2;
  localparam logic [2:0] REG_PRESS_NINE = 3'd3;
  localparam logic [2:0] REG_HUM        = 3'd4;

  localparam logic [63:0] PRESS_OFFSET = 64'd128000;
  localparam logic [63:0] PRESS_FULL   = 64'd1048576;
  localparam logic [63:0] PRESS_SCALE  = 64'd3125;
  localparam logic [63:0] HUM_OFFSET   = 64'd76800;
  localparam logic [63:0] HUM_CLAMP    = 64'd419430400;
  localparam logic [63:0] HUM_ROUND    = 64'd16384;
  localparam logic [63:0] HUM_BASE     = 64'd2097152;
  localparam logic [63:0] HUM_ROUND2   = 64'd8192;
  localparam logic [63:0] HUM_MID      = 64'd32768;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_RUN   = 5'b00010,
    S_MWAIT = 5'b00100,
    S_DWAIT = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
  } mul_req_t;

  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [63:0] den;
  } div_req_t;

  function automatic logic [63:0] sar(input logic [63:0] x, input logic [5:0] s);
    return 64'($signed(x) >>> s);
  endfunction

  function automatic logic [63:0] sx32(input logic [31:0] x);
    return {{32{x[31]}}, x};
  endfunction

  function automatic logic [63:0] sx16(input logic [15:0] x);
    return {{48{x[15]}}, x};
  endfunction

  function automatic logic [63:0] sx12(input logic [11:0] x);
    return {{52{x[11]}}, x};
  endfunction

  function automatic logic [63:0] sx8(input logic [7:0] x);
    return {{56{x[7]}}, x};
  endfunction

endpackage
`default_nettype wire

### hw/rtl/hpt_in_if.sv
`default_nettype none
interface hpt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [19:0] raw;
  modport source (output valid, output func, output raw, input ready);
  modport sink (input valid, input func, input raw, output ready);
endinterface
`default_nettype wire

### hw/rtl/hpt_out_if.sv
`default_nettype none
interface hpt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] value;
  logic        div_zero;
  modport source (output valid, output kind, output value, output div_zero, input ready);
  modport sink (input valid, input kind, input value, input div_zero, output ready);
endinterface
`default_nettype wire

### hw/rtl/humidity_pressure_temp_compensation_top.sv
`default_nettype none
// Channel  | Dir | Payload                         | Transfer
// in_ch    | in  | func[1:0], raw[19:0]            | valid & ready
// out_ch   | out | kind[1:0], value[31:0], div_zero| valid & ready
// cfg      | in  | cfg_index[2:0], cfg_data[63:0]  | cfg_we
//
// One item at a time. Each product goes to a shift-add multiplier (1 bit/cycle,
// stops when the multiplier operand runs out of bits) and the pressure quotient
// to a restoring divider. Temperature takes 4 products, humidity 8, pressure 10
// plus the division; an unused kind goes straight to DONE. Sync reset clears
// control, coefficients, fine temp. A new item is taken while a result waits;
// the next result holds in DONE.
module humidity_pressure_temp_compensation_top (
  input  wire logic        clk,
  input  wire logic        rst,
  hpt_in_if.sink           in_ch,
  hpt_out_if.source        out_ch,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);

  // coefficient registers
  logic [47:0] temp_coeffs;
  logic [63:0] press_coeffs_low;
  logic [63:0] press_coeffs_high;
  logic [15:0] press_coeff_nine;
  logic [63:0] hum_coeffs;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_coeffs       <= '0;
      press_coeffs_low  <= '0;
      press_coeffs_high <= '0;
      press_coeff_nine  <= '0;
      hum_coeffs        <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        hpt_pkg::REG_TEMP:       temp_coeffs       <= cfg_data[47:0];
        hpt_pkg::REG_PRESS_LOW:  press_coeffs_low  <= cfg_data;
        hpt_pkg::REG_PRESS_HIGH: press_coeffs_high <= cfg_data;
        hpt_pkg::REG_PRESS_NINE: press_coeff_nine  <= cfg_data[15:0];
        hpt_pkg::REG_HUM:        hum_coeffs        <= cfg_data;
        default: ;
      endcase
    end
  end

  // coefficient fields, widened to 64 bits
  logic [63:0] t1, t2, t3;
  logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
  logic [63:0] h1, h2, h3, h4, h5, h6;

  assign t1 = {48'd0, temp_coeffs[15:0]};
  assign t2 = hpt_pkg::sx16(temp_coeffs[31:16]);
  assign t3 = hpt_pkg::sx16(temp_coeffs[47:32]);
  assign p1 = {48'd0, press_coeffs_low[15:0]};
  assign p2 = hpt_pkg::sx16(press_coeffs_low[31:16]);
  assign p3 = hpt_pkg::sx16(press_coeffs_low[47:32]);
  assign p4 = hpt_pkg::sx16(press_coeffs_low[63:48]);
  assign p5 = hpt_pkg::sx16(press_coeffs_high[15:0]);
  assign p6 = hpt_pkg::sx16(press_coeffs_high[31:16]);
  assign p7 = hpt_pkg::sx16(press_coeffs_high[47:32]);
  assign p8 = hpt_pkg::sx16(press_coeffs_high[63:48]);
  assign p9 = hpt_pkg::sx16(press_coeff_nine);
  assign h1 = {56'd0, hum_coeffs[7:0]};
  assign h2 = hpt_pkg::sx16(hum_coeffs[23:8]);
  assign h3 = {56'd0, hum_coeffs[31:24]};
  assign h4 = hpt_pkg::sx12(hum_coeffs[43:32]);
  assign h5 = hpt_pkg::sx12(hum_coeffs[55:44]);
  assign h6 = hpt_pkg::sx8(hum_coeffs[63:56]);

  // sequencer state
  hpt_pkg::state_t state, state_next;
  logic [3:0]  pc, pc_next;
  logic [1:0]  func_r;
  logic [19:0] raw_r;
  logic [63:0] r0, r1, r2, r3;
  logic [63:0] r0_next, r1_next, r2_next, r3_next;
  logic [31:0] ft, ft_next;
  logic        neg, neg_next;
  logic [31:0] res_value, res_value_next;
  logic        res_dz, res_dz_next;

  // output register
  logic        ov;
  logic [1:0]  out_kind;
  logic [31:0] out_value;
  logic        out_dz;
  logic        load_out;

  hpt_pkg::mul_req_t mreq;
  hpt_pkg::div_req_t dreq;
  logic [63:0] prod, quo;
  logic        mul_busy, div_busy;

  hpt_mul u_mul (.clk(clk), .rst(rst), .req(mreq), .busy(mul_busy), .prod(prod));
  hpt_div u_div (.clk(clk), .rst(rst), .req(dreq), .busy(div_busy), .quo(quo));

  logic [63:0] a64;
  assign a64 = {44'd0, raw_r};

  assign in_ch.ready = (state == hpt_pkg::S_IDLE);
  assign load_out    = (state == hpt_pkg::S_DONE) && (!ov || out_ch.ready);

  always_comb begin
    logic [63:0] ta;
    logic [63:0] tb;
    ta             = '0;
    tb             = '0;
    state_next     = state;
    pc_next        = pc;
    r0_next        = r0;
    r1_next        = r1;
    r2_next        = r2;
    r3_next        = r3;
    ft_next        = ft;
    neg_next       = neg;
    res_value_next = res_value;
    res_dz_next    = res_dz;
    mreq           = '0;
    dreq           = '0;
    case (state)
      hpt_pkg::S_IDLE: begin
        if (in_ch.valid) begin
          state_next = hpt_pkg::S_RUN;
          pc_next    = '0;
        end
      end
      hpt_pkg::S_RUN: begin
        case (func_r)
          hpt_pkg::FUNC_TEMP: begin
            case (pc)
              4'd0: begin
                mreq = '{1'b1, (a64 >> 3) - (t1 << 1), t2};
              end
              4'd1: begin
                r0_next = hpt_pkg::sar(prod, 6'd11);
                ta      = (a64 >> 4) - t1;
                mreq    = '{1'b1, ta, ta};
              end
              4'd2: begin
                mreq = '{1'b1, hpt_pkg::sar(prod, 6'd12), t3};
              end
              4'd3: begin
                ta      = r0 + hpt_pkg::sar(prod, 6'd14);
                ft_next = ta[31:0];
                mreq    = '{1'b1, hpt_pkg::sx32(ta[31:0]), 64'd5};
              end
              default: begin
                ta             = hpt_pkg::sar(prod + 64'd128, 6'd8);
                res_value_next = ta[31:0];
                res_dz_next    = 1'b0;
                state_next     = hpt_pkg::S_DONE;
              end
            endcase
          end
          hpt_pkg::FUNC_PRESS: begin
            case (pc)
              4'd0: begin
                ta      = hpt_pkg::sx32(ft) - hpt_pkg::PRESS_OFFSET;
                r0_next = ta;
                mreq    = '{1'b1, ta, ta};
              end
              4'd1: begin
                r1_next = prod;
                mreq    = '{1'b1, prod, p6};
              end
              4'd2: begin
                r2_next = prod;
                mreq    = '{1'b1, r0, p5};
              end
              4'd3: begin
                r2_next = r2 + (prod << 17) + (p4 << 35);
                mreq    = '{1'b1, r1, p3};
              end
              4'd4: begin
                r3_next = hpt_pkg::sar(prod, 6'd8);
                mreq    = '{1'b1, r0, p2};
              end
              4'd5: begin
                ta   = r3 + (prod << 12);
                mreq = '{1'b1, (64'd1 << 47) + ta, p1};
              end
              4'd6: begin
                ta      = hpt_pkg::sar(prod, 6'd33);
                r0_next = ta;
                if (ta == '0) begin
                  // zero divisor: result forced to zero and flagged
                  res_value_next = '0;
                  res_dz_next    = 1'b1;
                  state_next     = hpt_pkg::S_DONE;
                end else begin
                  tb   = hpt_pkg::PRESS_FULL - a64;
                  mreq = '{1'b1, (tb << 31) - r2, hpt_pkg::PRESS_SCALE};
                end
              end
              4'd7: begin
                neg_next   = prod[63] ^ r0[63];
                ta         = prod[63] ? (64'd0 - prod) : prod;
                tb         = r0[63] ? (64'd0 - r0) : r0;
                dreq       = '{1'b1, ta, tb};
                state_next = hpt_pkg::S_DWAIT;
              end
              4'd8: begin
                ta      = neg ? (64'd0 - quo) : quo;
                r1_next = ta;
                mreq    = '{1'b1, hpt_pkg::sar(ta, 6'd13), p9};
              end
              4'd9: begin
                mreq = '{1'b1, prod, hpt_pkg::sar(r1, 6'd13)};
              end
              4'd10: begin
                r2_next = hpt_pkg::sar(prod, 6'd25);
                mreq    = '{1'b1, p8, r1};
              end
              4'd11: begin
                r3_next = r1 + r2 + hpt_pkg::sar(prod, 6'd19);
                pc_next = pc + 1'b1;
              end
              default: begin
                ta = hpt_pkg::sar(r3, 6'd8) + (p7 << 4);
                // saturate to signed 32 bits
                if ($signed(ta) < -64'sd2147483648) begin
                  res_value_next = 32'h8000_0000;
                end else if ($signed(ta) > 64'sd2147483647) begin
                  res_value_next = 32'h7FFF_FFFF;
                end else begin
                  res_value_next = ta[31:0];
                end
                res_dz_next = 1'b0;
                state_next  = hpt_pkg::S_DONE;
              end
            endcase
          end
          hpt_pkg::FUNC_HUM: begin
            case (pc)
              4'd0: begin
                ta      = hpt_pkg::sx32(ft) - hpt_pkg::HUM_OFFSET;
                r0_next = ta;
                mreq    = '{1'b1, h5, ta};
              end
              4'd1: begin
                ta      = ({48'd0, raw_r[15:0]} << 14) - (h4 << 20) - prod
                          + hpt_pkg::HUM_ROUND;
                r1_next = hpt_pkg::sar(ta, 6'd15);
                mreq    = '{1'b1, r0, h6};
              end
              4'd2: begin
                r2_next = hpt_pkg::sar(prod, 6'd10);
                mreq    = '{1'b1, r0, h3};
              end
              4'd3: begin
                mreq = '{1'b1, r2, hpt_pkg::sar(prod, 6'd11) + hpt_pkg::HUM_MID};
              end
              4'd4: begin
                mreq = '{1'b1, hpt_pkg::sar(prod, 6'd10) + hpt_pkg::HUM_BASE, h2};
              end
              4'd5: begin
                mreq = '{1'b1, r1, hpt_pkg::sar(prod + hpt_pkg::HUM_ROUND2, 6'd14)};
              end
              4'd6: begin
                r0_next = prod;
                ta      = hpt_pkg::sar(prod, 6'd15);
                mreq    = '{1'b1, ta, ta};
              end
              4'd7: begin
                mreq = '{1'b1, hpt_pkg::sar(prod, 6'd7), h1};
              end
              default: begin
                ta = r0 - hpt_pkg::sar(prod, 6'd4);
                // clamp to [0, full scale] before the final shift
                if (ta[63]) begin
                  ta = '0;
                end else if (ta > hpt_pkg::HUM_CLAMP) begin
                  ta = hpt_pkg::HUM_CLAMP;
                end
                tb             = ta >> 12;
                res_value_next = tb[31:0];
                res_dz_next    = 1'b0;
                state_next     = hpt_pkg::S_DONE;
              end
            endcase
          end
          default: begin
            res_value_next = '0;
            res_dz_next    = 1'b0;
            state_next     = hpt_pkg::S_DONE;
          end
        endcase
        if (mreq.start) begin
          state_next = hpt_pkg::S_MWAIT;
        end
      end
      hpt_pkg::S_MWAIT: begin
        if (!mul_busy) begin
          pc_next    = pc + 1'b1;
          state_next = hpt_pkg::S_RUN;
        end
      end
      hpt_pkg::S_DWAIT: begin
        if (!div_busy) begin
          pc_next    = pc + 1'b1;
          state_next = hpt_pkg::S_RUN;
        end
      end
      hpt_pkg::S_DONE: begin
        if (load_out) begin
          state_next = hpt_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = hpt_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hpt_pkg::S_IDLE;
      pc    <= '0;
      ft    <= '0;
      ov    <= 1'b0;
    end else begin
      state <= state_next;
      pc    <= pc_next;
      ft    <= ft_next;
      if (load_out) begin
        ov <= 1'b1;
      end else if (out_ch.ready) begin
        ov <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      func_r <= in_ch.func;
      raw_r  <= in_ch.raw;
    end
    r0        <= r0_next;
    r1        <= r1_next;
    r2        <= r2_next;
    r3        <= r3_next;
    neg       <= neg_next;
    res_value <= res_value_next;
    res_dz    <= res_dz_next;
    if (load_out) begin
      out_kind  <= func_r;
      out_value <= res_value;
      out_dz    <= res_dz;
    end
  end

  assign out_ch.valid    = ov;
  assign out_ch.kind     = out_kind;
  assign out_ch.value    = out_value;
  assign out_ch.div_zero = out_dz;

  // a product is only requested once the previous one has finished
  a_mul_idle: assert property (@(posedge clk) disable iff (rst)
    mreq.start |-> !mul_busy)
    else $error("multiplier started while busy");

  // only pressure uses the divider
  a_div_press: assert property (@(posedge clk) disable iff (rst)
    dreq.start |-> (func_r == hpt_pkg::FUNC_PRESS))
    else $error("divider started outside pressure");

  // the fine temperature term is rewritten only by a temperature item
  a_ft_temp: assert property (@(posedge clk) disable iff (rst || $past(rst))
    (ft != $past(ft)) |-> ($past(func_r) == hpt_pkg::FUNC_TEMP))
    else $error("fine temperature changed outside temperature");

endmodule
`default_nettype wire

### hw/rtl/hpt_mul.sv
`default_nettype none
// shift-add multiplier, one multiplier bit per cycle, product mod 2^64
module hpt_mul (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire hpt_pkg::mul_req_t req,
  output logic                  busy,
  output logic [63:0]           prod
);
  logic [63:0] a;
  logic [63:0] b;
  logic [63:0] acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      b <= '0;
    end else if (req.start) begin
      a   <= req.a;
      b   <= req.b;
      acc <= '0;
    end else if (busy) begin
      if (b[0]) begin
        acc <= acc + a;
      end
      a <= a << 1;
      b <= b >> 1;
    end
  end

  // stops as soon as no multiplier bits remain
  assign busy = (b != '0);
  assign prod = acc;
endmodule
`default_nettype wire

### hw/rtl/hpt_div.sv
`default_nettype none
// restoring unsigned divider, one quotient bit per cycle
module hpt_div (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire hpt_pkg::div_req_t req,
  output logic                  busy,
  output logic [63:0]           quo
);
  logic [63:0] rem;
  logic [63:0] q;
  logic [63:0] den;
  logic [hpt_pkg::CNT_W-1:0] cnt;
  logic [64:0] trial;

  assign trial = {rem, q[63]};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (req.start) begin
      rem <= '0;
      q   <= req.num;
      den <= req.den;
      cnt <= hpt_pkg::CNT_W'(hpt_pkg::WORD_W);
    end else if (busy) begin
      if (trial >= {1'b0, den}) begin
        rem <= 64'(trial - {1'b0, den});
        q   <= {q[62:0], 1'b1};
      end else begin
        rem <= trial[63:0];
        q   <= {q[62:0], 1'b0};
      end
      cnt <= cnt - 1'b1;
    end
  end

  assign busy = (cnt != '0);
  assign quo  = q;
endmodule
`default_nettype wire

### sim/humidity_pressure_temp_compensation_top_tb.sv
`default_nettype none
module humidity_pressure_temp_compensation_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [63:0] w64;

  // one compensated reading as it leaves the block
  typedef struct {
    logic [1:0]  kind;
    logic [31:0] value;
    logic        div_zero;
  } reading_t;

  // directed row: typed expectation only where it is obvious
  typedef struct {
    logic [1:0]  func;
    logic [19:0] raw;
    bit          typed;
    logic [31:0] value;
    logic        div_zero;
  } row_t;

  typedef enum int {
    CAL_ZERO, CAL_TYPICAL, CAL_ONES, CAL_MAXPOS, CAL_MINNEG, CAL_RANDOM
  } cal_style_t;

  localparam int unsigned CYCLE_LIMIT = 6_000_000;
  localparam int unsigned LONG_HOLD   = 400;
  localparam int unsigned SETTLE      = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic        cfg_we    = 1'b0;
  logic [2:0]  cfg_index = hpt_pkg::REG_TEMP;
  logic [63:0] cfg_data  = '0;

  hpt_in_if  in_ch ();
  hpt_out_if out_ch ();

  humidity_pressure_temp_compensation_top uut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor copy of the calibration registers and the fine temperature
  w64          cal_temp, cal_press_lo, cal_press_hi, cal_press_nine, cal_hum;
  logic [31:0] t_fine;

  reading_t pending_readings[$];
  int       errors    = 0;
  int       cycles    = 0;
  bit       hold_req  = 1'b0;  // source asks the sink for one long hold-off
  bit       no_gaps   = 1'b0;  // stretch with no idling on either side

  function automatic w64 ash(w64 x, int s);
    return w64'($signed(x) >>> s);
  endfunction

  function automatic w64 sgn(w64 x, int bits);
    w64 m;
    m = w64'(1) << (bits - 1);
    x = x & ((w64'(1) << bits) - 1);
    return (x ^ m) - m;
  endfunction

  function automatic w64 quot_trunc(w64 n, w64 d);
    w64 an, ad, q;
    an = n[63] ? -n : n;
    ad = d[63] ? -d : d;
    q  = an / ad;
    return (n[63] != d[63]) ? -q : q;
  endfunction

  function automatic logic [31:0] comp_temp(w64 a);
    w64 t1, t2, t3, v1, v2, d, ft;
    t1 = w64'(cal_temp[15:0]);
    t2 = sgn(cal_temp >> 16, 16);
    t3 = sgn(cal_temp >> 32, 16);
    v1 = ash(((a >> 3) - (t1 << 1)) * t2, 11);
    d  = (a >> 4) - t1;
    v2 = ash(ash(d * d, 12) * t3, 14);
    t_fine = 32'(v1 + v2);
    ft = sgn(w64'(t_fine), 32);
    return 32'(ash(ft * 64'd5 + 64'd128, 8));
  endfunction

  function automatic logic [31:0] comp_press(w64 a, output logic dz);
    w64 p1, p2, p3, p4, p5, p6, p7, p8, p9, v1, v2, p;
    p1 = w64'(cal_press_lo[15:0]);
    p2 = sgn(cal_press_lo >> 16, 16);
    p3 = sgn(cal_press_lo >> 32, 16);
    p4 = sgn(cal_press_lo >> 48, 16);
    p5 = sgn(cal_press_hi, 16);
    p6 = sgn(cal_press_hi >> 16, 16);
    p7 = sgn(cal_press_hi >> 32, 16);
    p8 = sgn(cal_press_hi >> 48, 16);
    p9 = sgn(cal_press_nine, 16);
    v1 = sgn(w64'(t_fine), 32) - hpt_pkg::PRESS_OFFSET;
    v2 = v1 * v1 * p6;
    v2 = v2 + ((v1 * p5) << 17);
    v2 = v2 + (p4 << 35);
    v1 = ash(v1 * v1 * p3, 8) + ((v1 * p2) << 12);
    v1 = ash(((w64'(1) << 47) + v1) * p1, 33);
    dz = 1'b0;
    if (v1 == 0) begin
      dz = 1'b1;
      return '0;
    end
    p  = hpt_pkg::PRESS_FULL - a;
    p  = quot_trunc(((p << 31) - v2) * hpt_pkg::PRESS_SCALE, v1);
    v1 = ash(p9 * ash(p, 13) * ash(p, 13), 25);
    v2 = ash(p8 * p, 19);
    p  = ash(p + v1 + v2, 8) + (p7 << 4);
    // saturate to signed 32 bits
    if ($signed(p) < -64'sd2147483648)
      p = 64'hFFFF_FFFF_8000_0000;
    else if ($signed(p) > 64'sd2147483647)
      p = 64'h7FFF_FFFF;
    return p[31:0];
  endfunction

  function automatic logic [31:0] comp_hum(w64 a);
    w64 h1, h2, h3, h4, h5, h6, adc, v, x, y;
    h1  = w64'(cal_hum[7:0]);
    h2  = sgn(cal_hum >> 8, 16);
    h3  = w64'(cal_hum[31:24]);
    h4  = sgn(cal_hum >> 32, 12);
    h5  = sgn(cal_hum >> 44, 12);
    h6  = sgn(cal_hum >> 56, 8);
    adc = a & 64'hFFFF;
    v   = sgn(w64'(t_fine), 32) - hpt_pkg::HUM_OFFSET;
    x   = ash((adc << 14) - (h4 << 20) - h5 * v + hpt_pkg::HUM_ROUND, 15);
    y   = ash(ash(v * h6, 10) * (ash(v * h3, 11) + hpt_pkg::HUM_MID), 10)
          + hpt_pkg::HUM_BASE;
    y   = ash(y * h2 + hpt_pkg::HUM_ROUND2, 14);
    v   = x * y;
    v   = v - ash(ash(ash(v, 15) * ash(v, 15), 7) * h1, 4);
    if (v[63])
      v = '0;
    else if (v > hpt_pkg::HUM_CLAMP)
      v = hpt_pkg::HUM_CLAMP;
    return 32'(v >> 12);
  endfunction

  function automatic reading_t compensate(logic [1:0] f, logic [19:0] r);
    reading_t o;
    w64       a;
    a = w64'(r);
    o.kind = f;
    o.value = '0;
    o.div_zero = 1'b0;
    case (f)
      hpt_pkg::FUNC_TEMP:  o.value = comp_temp(a);
      hpt_pkg::FUNC_PRESS: o.value = comp_press(a, o.div_zero);
      hpt_pkg::FUNC_HUM:   o.value = comp_hum(a);
      default:             o.value = '0;  // unused selector
    endcase
    return o;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int gap_len();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // stop offering, then wait until the block is idle
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // writes all five registers back to back; write enable dropped once at the end
  task automatic load_cal(cal_style_t sty);
    w64 vals[5];
    w64 raw_val;
    for (int i = 0; i < 5; i++) begin
      case (sty)
        CAL_ZERO:   raw_val = '0;
        CAL_ONES:   raw_val = '1;
        CAL_MAXPOS: raw_val = 64'h7FFF_7FFF_7FFF_FFFF;
        CAL_MINNEG: raw_val = 64'h8000_8000_8000_0000;
        CAL_RANDOM: raw_val = {$urandom, $urandom};
        default:    raw_val = '0;
      endcase
      vals[i] = raw_val;
    end
    if (sty == CAL_TYPICAL) begin
      vals[hpt_pkg::REG_TEMP]       = {16'hFC18, 16'd26435, 16'd27504};
      vals[hpt_pkg::REG_PRESS_LOW]  = {16'd2855, 16'd3024, 16'hD643, 16'd36477};
      vals[hpt_pkg::REG_PRESS_HIGH] = {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140};
      vals[hpt_pkg::REG_PRESS_NINE] = 64'd6000;
      vals[hpt_pkg::REG_HUM]        = {8'd30, 12'd50, 12'd313, 8'd0, 16'd362, 8'd75};
    end
    for (int i = 0; i < 5; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data  <= vals[i];
      @(posedge clk);
      case (3'(i))
        hpt_pkg::REG_TEMP:       cal_temp       = vals[i] & 64'hFFFF_FFFF_FFFF;
        hpt_pkg::REG_PRESS_LOW:  cal_press_lo   = vals[i];
        hpt_pkg::REG_PRESS_HIGH: cal_press_hi   = vals[i];
        hpt_pkg::REG_PRESS_NINE: cal_press_nine = vals[i] & 64'hFFFF;
        hpt_pkg::REG_HUM:        cal_hum        = vals[i];
        default: ;
      endcase
    end
    cfg_we <= 1'b0;
  endtask

  // offers one reading; optional typed expectation replaces the predicted one
  task automatic offer(logic [1:0] f, logic [19:0] r, bit typed = 0,
                       logic [31:0] tv = '0, logic tdz = 1'b0);
    reading_t e;
    int       g;
    in_ch.valid <= 1'b1;
    in_ch.func  <= f;
    in_ch.raw   <= r;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    e = compensate(f, r);  // keeps fine temperature in step either way
    if (typed) begin
      e.value    = tv;
      e.div_zero = tdz;
    end
    pending_readings.push_back(e);
    g = gap_len();
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // directed readings with reset calibration: everything collapses to zero,
  // pressure divisor is zero
  row_t reset_rows[7] = '{
    '{hpt_pkg::FUNC_TEMP,  20'h00000, 1, 32'd0, 1'b0},
    '{hpt_pkg::FUNC_TEMP,  20'hFFFFF, 1, 32'd0, 1'b0},
    '{hpt_pkg::FUNC_PRESS, 20'h00000, 1, 32'd0, 1'b1},
    '{hpt_pkg::FUNC_PRESS, 20'hFFFFF, 1, 32'd0, 1'b1},
    '{hpt_pkg::FUNC_HUM,   20'h00000, 1, 32'd0, 1'b0},
    '{hpt_pkg::FUNC_HUM,   20'hFFFFF, 1, 32'd0, 1'b0},
    '{2'd3,                20'hFFFFF, 1, 32'd0, 1'b0}
  };

  // directed readings with typical calibration, checked by the predictor
  row_t typ_rows[12] = '{
    '{hpt_pkg::FUNC_TEMP,  20'd519888,  0, 32'd0, 1'b0},
    '{hpt_pkg::FUNC_PRESS, 20'd415148,  0, 32'd0, 1'b0},
    '{hpt_pkg::FUNC_HUM,   20'h06A3C,   0, 32'd0, 1'b0},
    '{hpt_pkg::FUNC_PRESS, 20'h00000,   0, 32'd0, 1'b0},
    '{hpt_pkg::FUNC_PRESS, 20'hFFFFF,   0, 32'd0, 1'b0},
    '{hpt_pkg::FUNC_HUM,   20'h00000,   0, 32'd0, 1'b0},
    '{hpt_pkg::FUNC_HUM,   20'hFFFFF,   0, 32'd0, 1'b0},
    '{hpt_pkg::FUNC_TEMP,  20'h00000,   0, 32'd0, 1'b0},
    '{hpt_pkg::FUNC_PRESS, 20'd415148,  0, 32'd0, 1'b0},
    '{hpt_pkg::FUNC_TEMP,  20'hFFFFF,   0, 32'd0, 1'b0},
    '{hpt_pkg::FUNC_HUM,   20'h0FFFF,   0, 32'd0, 1'b0},
    '{2'd3,                20'h00000,   0, 32'd0, 1'b0}
  };

  // ---------------------------------------------------------------------------
  // stimulus: reset, directed rows, then calibration phases of random traffic
  // ---------------------------------------------------------------------------
  initial begin
    cal_style_t  styles[8];
    logic [1:0]  f;
    logic [19:0] r;
    int          burst;
    bit          held;
    bit          paused;
    held   = 1'b0;
    paused = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.func  = hpt_pkg::FUNC_TEMP;
    in_ch.raw   = '0;
    cal_temp = '0; cal_press_lo = '0; cal_press_hi = '0;
    cal_press_nine = '0; cal_hum = '0; t_fine = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (reset_rows[i])
      offer(reset_rows[i].func, reset_rows[i].raw, reset_rows[i].typed,
            reset_rows[i].value, reset_rows[i].div_zero);
    drain();
    load_cal(CAL_TYPICAL);
    foreach (typ_rows[i])
      offer(typ_rows[i].func, typ_rows[i].raw);

    styles = '{CAL_TYPICAL, CAL_RANDOM, CAL_ONES, CAL_TYPICAL,
               CAL_MAXPOS, CAL_RANDOM, CAL_MINNEG, CAL_RANDOM};
    foreach (styles[ph]) begin
      drain();
      load_cal(styles[ph]);
      no_gaps = (ph == 3);  // one stretch at full rate
      for (int n = 0; n < 190; ) begin
        if (ph == 1 && n >= 40 && !held) begin
          hold_req = 1'b1;   // receiver backs up
          held     = 1'b1;
        end
        if (ph == 5 && n >= 90 && !paused) begin
          drain();           // sender waits for all results
          paused = 1'b1;
        end
        if ($urandom_range(0, 99) < 75) begin
          // well-formed: temperature first, then readings that use it
          r = (styles[ph] == CAL_TYPICAL) ? 20'($urandom_range(400000, 640000))
                                          : 20'($urandom);
          offer(hpt_pkg::FUNC_TEMP, r);
          burst = $urandom_range(1, 4);
          for (int k = 0; k < burst; k++) begin
            f = ($urandom_range(0, 1) != 0) ? hpt_pkg::FUNC_PRESS : hpt_pkg::FUNC_HUM;
            offer(f, 20'($urandom));
          end
          n += burst + 1;
        end else begin
          offer(2'($urandom_range(0, 3)), 20'($urandom));
          n++;
        end
      end
    end

    in_ch.valid <= 1'b0;
    drain();
    if (errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // sink side: random ready gaps, one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    int idle;
    idle = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 1'b0;
      end else if (idle > 0) begin
        out_ch.ready <= 1'b0;
        idle--;
      end else begin
        out_ch.ready <= 1'b1;
        idle = gap_len();
      end
    end
  end

  // result check: each transfer against the oldest expectation
  always @(posedge clk) begin
    reading_t e;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_readings.size() == 0) begin
        $error("unexpected result kind=%0d value=%h", out_ch.kind, out_ch.value);
        errors++;
      end else begin
        e = pending_readings.pop_front();
        if (out_ch.kind !== e.kind) begin
          $error("kind: expected %0d, got %0d", e.kind, out_ch.kind);
          errors++;
        end
        if (out_ch.value !== e.value) begin
          $error("value: expected %h, got %h", e.value, out_ch.value);
          errors++;
        end
        if (out_ch.div_zero !== e.div_zero) begin
          $error("div_zero: expected %b, got %b", e.div_zero, out_ch.div_zero);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

endmodule
`default_nettype wire
